FILE: rtl/core/grouped_class_queue_defines.svh
// assertion macros of the grouped class queue checker
`ifndef GROUPED_CLASS_QUEUE_DEFINES_SVH
`define GROUPED_CLASS_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GCQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define GCQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gcq_pkg.sv
// types and constants of the grouped class queue
package gcq_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned CLS_IN_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ID_RANGE = 1 << ID_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP = 2'd0,
    ACT_ENQ = 2'd1,
    ACT_DEQ = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_OUT   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

FILE: rtl/core/gcq_if.sv
// valid/ready channel interfaces of the grouped class queue
interface gcq_in_if import gcq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     item_id;
  logic [CLS_IN_W-1:0] class_id;

  modport source (output valid, action, item_id, class_id, input ready);
  modport sink   (input valid, action, item_id, class_id, output ready);
endinterface

interface gcq_out_if import gcq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;

  modport source (output valid, status, out_id, input ready);
  modport sink   (input valid, status, out_id, output ready);
endinterface

FILE: rtl/core/grouped_class_queue.sv
// grouped class queue: ids queue behind their class, classes served in arrival order
// one transaction in flight; map, unused codes and an empty dequeue go from acceptance
// straight to the result step; enqueue and dequeue read one ram after another (class map
// or order ring, then class head/count), then enqueue writes and dequeue reads the item ring
// results sit in an output register, so a stalled sink holds the next item in its last step
// after reset the class map is swept to zero, one entry a cycle, and no input is taken
// until the sweep ends
module grouped_class_queue import gcq_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 16,
  parameter int unsigned ID_SPACE    = 4096,
  parameter int unsigned CLASS_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcq_in_if.sink    in_i,
  gcq_out_if.source out_o
);

  // widths derived from the configuration
  localparam int unsigned CW        = $clog2(NUM_CLASSES);
  localparam int unsigned OCW       = $clog2(NUM_CLASSES + 1);
  localparam int unsigned OSW       = CW + 1;
  localparam int unsigned HW        = $clog2(CLASS_DEPTH);
  localparam int unsigned SW        = HW + 1;
  localparam int unsigned CNTW      = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned CTRL_W    = HW + CNTW;
  localparam int unsigned MAP_DEPTH = (ID_SPACE < ID_RANGE) ? ID_SPACE : ID_RANGE;
  localparam int unsigned MAW       = $clog2(MAP_DEPTH);
  localparam int unsigned ITEMS     = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned IAW       = $clog2(ITEMS);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_ENQ_CTRL = 7'b0000100,
    S_ENQ_WR   = 7'b0001000,
    S_DEQ_CTRL = 7'b0010000,
    S_DEQ_ITEM = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [MAW-1:0]         clr_addr_q, clr_addr_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic                   id_ok_q, id_ok_d;
  logic [CW-1:0]          cls_q, cls_d;
  logic [CW-1:0]          ord_head_q, ord_head_d;
  logic [OCW-1:0]         ord_cnt_q, ord_cnt_d;
  logic [NUM_CLASSES-1:0] ctrl_vld_q, ctrl_vld_d;
  status_e                res_status_q, res_status_d;
  logic                   res_item_q, res_item_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [ID_W-1:0]        out_id_q, out_id_d;

  // ram ports
  logic              map_we, map_re;
  logic [MAW-1:0]    map_waddr, map_raddr;
  logic [CW-1:0]     map_wdata, map_rdata;
  logic              ctrl_we, ctrl_re;
  logic [CW-1:0]     ctrl_waddr, ctrl_raddr;
  logic [CTRL_W-1:0] ctrl_wdata, ctrl_rdata;
  logic              ord_we, ord_re;
  logic [CW-1:0]     ord_waddr, ord_raddr;
  logic [CW-1:0]     ord_wdata, ord_rdata;
  logic              item_we, item_re;
  logic [IAW-1:0]    item_waddr, item_raddr;
  logic [ID_W-1:0]   item_wdata, item_rdata;

  logic              in_acc, out_free;
  logic [CTRL_W-1:0] ctrl_cur;
  logic [HW-1:0]     cur_head;
  logic [CNTW-1:0]   cur_cnt;
  logic [SW-1:0]     slot_sum, head_sum;
  logic [HW-1:0]     slot, head_nxt;
  logic [OSW-1:0]    tail_sum, ohead_sum;
  logic [CW-1:0]     ord_tail, ord_head_nxt;
  logic [IAW-1:0]    cls_base;
  logic              in_id_ok;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = !out_valid_q | out_o.ready;
  assign in_id_ok   = 32'(in_i.item_id) < ID_SPACE;

  // a class never written reads as head 0, count 0
  assign ctrl_cur = ctrl_vld_q[cls_q] ? ctrl_rdata : '0;
  assign cur_head = ctrl_cur[CTRL_W-1:CNTW];
  assign cur_cnt  = ctrl_cur[CNTW-1:0];

  // ring slot of the new tail: head + count wrapped once
  assign slot_sum = SW'(cur_head) + SW'(cur_cnt);
  assign slot     = (slot_sum >= SW'(CLASS_DEPTH)) ? HW'(slot_sum - SW'(CLASS_DEPTH))
                                                   : HW'(slot_sum);
  assign head_sum = SW'(cur_head) + SW'(1);
  assign head_nxt = (head_sum == SW'(CLASS_DEPTH)) ? '0 : HW'(head_sum);

  // class order ring tail and next head
  assign tail_sum     = OSW'(ord_head_q) + OSW'(ord_cnt_q);
  assign ord_tail     = (tail_sum >= OSW'(NUM_CLASSES)) ? CW'(tail_sum - OSW'(NUM_CLASSES))
                                                        : CW'(tail_sum);
  assign ohead_sum    = OSW'(ord_head_q) + OSW'(1);
  assign ord_head_nxt = (ohead_sum == OSW'(NUM_CLASSES)) ? '0 : CW'(ohead_sum);

  assign cls_base = IAW'(IAW'(cls_q) * IAW'(CLASS_DEPTH));

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    id_d         = id_q;
    id_ok_d      = id_ok_q;
    cls_d        = cls_q;
    ord_head_d   = ord_head_q;
    ord_cnt_d    = ord_cnt_q;
    ctrl_vld_d   = ctrl_vld_q;
    res_status_d = res_status_q;
    res_item_d   = res_item_q;
    out_valid_d  = out_valid_q & !out_o.ready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;

    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    map_re     = 1'b0;
    map_raddr  = '0;
    ctrl_we    = 1'b0;
    ctrl_waddr = cls_q;
    ctrl_wdata = '0;
    ctrl_re    = 1'b0;
    ctrl_raddr = '0;
    ord_we     = 1'b0;
    ord_waddr  = ord_tail;
    ord_wdata  = cls_q;
    ord_re     = 1'b0;
    ord_raddr  = ord_head_q;
    item_we    = 1'b0;
    item_waddr = cls_base + IAW'(slot);
    item_wdata = id_q;
    item_re    = 1'b0;
    item_raddr = cls_base + IAW'(cur_head);

    case (state_q)
      // zero sweep of the class map
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr_q;
        if (clr_addr_q == MAW'(MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + MAW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          id_d       = in_i.item_id;
          id_ok_d    = in_id_ok;
          res_item_d = 1'b0;
          case (in_i.action)
            ACT_MAP: begin
              // out-of-range id or class leaves the map alone
              if (in_id_ok && (32'(in_i.class_id) < NUM_CLASSES)) begin
                map_we    = 1'b1;
                map_waddr = in_i.item_id[MAW-1:0];
                map_wdata = CW'(in_i.class_id);
              end
              res_status_d = ST_DONE;
              state_d      = S_RESP;
            end
            ACT_ENQ: begin
              map_re    = 1'b1;
              map_raddr = in_i.item_id[MAW-1:0];
              state_d   = S_ENQ_CTRL;
            end
            ACT_DEQ: begin
              if (ord_cnt_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                ord_re  = 1'b1;
                state_d = S_DEQ_CTRL;
              end
            end
            default: begin
              res_status_d = ST_DONE;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      // class known: fetch its head and count
      S_ENQ_CTRL: begin
        cls_d      = id_ok_q ? map_rdata : '0;
        ctrl_re    = 1'b1;
        ctrl_raddr = id_ok_q ? map_rdata : '0;
        state_d    = S_ENQ_WR;
      end

      S_ENQ_WR: begin
        if (cur_cnt >= CNTW'(CLASS_DEPTH)) begin
          res_status_d = ST_FULL;
        end else begin
          item_we           = 1'b1;
          ctrl_we           = 1'b1;
          ctrl_wdata        = {cur_head, cur_cnt + CNTW'(1)};
          ctrl_vld_d[cls_q] = 1'b1;
          // an idle class joins the back of the order
          if ((cur_cnt == '0) && (ord_cnt_q < OCW'(NUM_CLASSES))) begin
            ord_we    = 1'b1;
            ord_cnt_d = ord_cnt_q + OCW'(1);
          end
          res_status_d = ST_DONE;
        end
        state_d = S_RESP;
      end

      // front class known: fetch its head and count
      S_DEQ_CTRL: begin
        cls_d      = ord_rdata;
        ctrl_re    = 1'b1;
        ctrl_raddr = ord_rdata;
        state_d    = S_DEQ_ITEM;
      end

      S_DEQ_ITEM: begin
        if (cur_cnt == '0) begin
          res_status_d = ST_EMPTY;
        end else begin
          item_re           = 1'b1;
          ctrl_we           = 1'b1;
          ctrl_wdata        = {head_nxt, cur_cnt - CNTW'(1)};
          ctrl_vld_d[cls_q] = 1'b1;
          // last id of the class: the class leaves the order
          if (cur_cnt == CNTW'(1)) begin
            ord_head_d = ord_head_nxt;
            ord_cnt_d  = ord_cnt_q - OCW'(1);
          end
          res_status_d = ST_OUT;
          res_item_d   = 1'b1;
        end
        state_d = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_item_q ? item_rdata : '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      ord_head_q  <= '0;
      ord_cnt_q   <= '0;
      ctrl_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      ord_head_q  <= ord_head_d;
      ord_cnt_q   <= ord_cnt_d;
      ctrl_vld_q  <= ctrl_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    id_ok_q      <= id_ok_d;
    cls_q        <= cls_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.out_id = out_id_q;

  // class of each id
  gcq_ram #(.WIDTH(CW), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // head and count of each class ring
  gcq_ram #(.WIDTH(CTRL_W), .DEPTH(NUM_CLASSES)) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (ctrl_waddr),
    .wdata_i (ctrl_wdata),
    .re_i    (ctrl_re),
    .raddr_i (ctrl_raddr),
    .rdata_o (ctrl_rdata)
  );

  // ring of waiting classes
  gcq_ram #(.WIDTH(CW), .DEPTH(NUM_CLASSES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // per-class id rings, one block of CLASS_DEPTH entries per class
  gcq_ram #(.WIDTH(ID_W), .DEPTH(ITEMS)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (item_we),
    .waddr_i (item_waddr),
    .wdata_i (item_wdata),
    .re_i    (item_re),
    .raddr_i (item_raddr),
    .rdata_o (item_rdata)
  );

endmodule

FILE: rtl/core/gcq_ram.sv
// generic single-write, single-read ram with registered read data
module gcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/gcq_checker.sv
// port-level checks of the grouped class queue and their binding
`include "grouped_class_queue_defines.svh"

module gcq_checker import gcq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] out_status_i,
  input logic [ID_W-1:0]     out_id_i
);

  // an id shows only on a dequeue
  `GCQ_ASSERT_IMP(a_id_only_on_out, out_valid_i && (out_status_i != ST_OUT), out_id_i == '0, "out_id set without a dequeue")

  // one transaction in flight at a time
  `GCQ_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  // a result never appears in the cycle after acceptance
  `GCQ_ASSERT_NXT(a_no_early_result, in_valid_i && in_ready_i, !$rose(out_valid_i), "result too early")

  // a stalled result holds
  `GCQ_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_id_i), "stalled result changed")

endmodule

bind grouped_class_queue gcq_checker u_gcq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_id_i     (out_o.out_id)
);
